[hdl/bwc_pkg.sv]
// ----------------------------------------------------------------------------
// bwc_pkg
// Shared constants, codes and types of the Bloom weightless classifier.
// ----------------------------------------------------------------------------
package bwc_pkg;

   localparam int TUPLE_BITS  = 16;
   localparam int FILTER_BITS = 10;
   localparam int RAM_BANKS   = 64;
   localparam int NUM_CLASSES = 10;

   localparam int SLICE_BITS  = 16;
   localparam int MAX_PROBES  = 4;

   localparam int MODE_W      = 2;
   localparam int KEY_IDX_W   = 4;
   localparam int KEY_W       = 64;
   localparam int RAM_IDX_W   = 6;
   localparam int TUPLE_W     = 16;
   localparam int LABEL_W     = 4;
   localparam int SCORE_W     = 7;
   localparam int PROBES_W    = 3;

   localparam int PROBE_SEL_W = $clog2(MAX_PROBES);
   localparam int SLICE_SHIFT = $clog2(SLICE_BITS);
   localparam int KEY_SEL_W   = $clog2(TUPLE_BITS);
   localparam int RAM_SEL_W   = $clog2(RAM_BANKS);
   localparam int CLASS_W     = $clog2(NUM_CLASSES);
   localparam int HASH_TAPS   = (TUPLE_BITS < TUPLE_W) ? TUPLE_BITS : TUPLE_W;

   localparam int BLOOM_DEPTH = RAM_BANKS * (2 ** FILTER_BITS);
   localparam int ADDR_W      = $clog2(BLOOM_DEPTH);

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRAIN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PREDICT = 2'd2;

   typedef struct packed {
      logic                 en;
      logic [KEY_SEL_W-1:0] sel;
      logic [KEY_W-1:0]     value;
   } key_wr_type;

   typedef struct packed {
      logic                   inc;
      logic [NUM_CLASSES-1:0] hit;
      logic                   take;
      logic [CLASS_W-1:0]     sel;
   } score_ctl_type;

endpackage

[hdl/bwc_ram.sv]
// ----------------------------------------------------------------------------
// bwc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bwc_hash.sv]
// ----------------------------------------------------------------------------
// bwc_hash
// H3 key file and hash: XOR of the keys selected by the set tuple bits.
// ----------------------------------------------------------------------------
module bwc_hash (
   input  logic                         clock,
   input  bwc_pkg::key_wr_type          key_wr,
   input  logic [bwc_pkg::TUPLE_W-1:0]  tuple,
   output logic [bwc_pkg::KEY_W-1:0]    hash
);
   import bwc_pkg::*;

   logic [KEY_W-1:0] keys_ff [TUPLE_BITS];

   always_ff @(posedge clock) begin
      if (key_wr.en) begin
         keys_ff[key_wr.sel] <= key_wr.value;
      end
   end

   always_comb begin
      hash = '0;
      for (int n = 0; n < HASH_TAPS; n++) begin
         if (tuple[n]) begin
            hash = hash ^ keys_ff[n];
         end
      end
   end

endmodule

[hdl/bwc_score.sv]
// ----------------------------------------------------------------------------
// bwc_score
// Per-class saturating score counters; a selected score is read and cleared.
// ----------------------------------------------------------------------------
module bwc_score (
   input  logic                         clock,
   input  logic                         reset,
   input  bwc_pkg::score_ctl_type       ctl,
   output logic [bwc_pkg::SCORE_W-1:0]  sel_score
);
   import bwc_pkg::*;

   logic [SCORE_W-1:0] score_ff [NUM_CLASSES];
   logic [SCORE_W-1:0] score_in [NUM_CLASSES];

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         score_in[c] = score_ff[c];
         if (ctl.inc && ctl.hit[c] && score_ff[c] != SCORE_MAX) begin
            score_in[c] = score_ff[c] + SCORE_W'(1);
         end
         if (ctl.take && ctl.sel == CLASS_W'(c)) begin
            score_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            score_ff[c] <= '0;
         end
      end else begin
         score_ff <= score_in;
      end
   end

   assign sel_score = score_ff[ctl.sel];

endmodule

[hdl/bloom_weightless_classifier.sv]
// ----------------------------------------------------------------------------
// bloom_weightless_classifier
// Bloom-filter weightless classifier with H3 hashing.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one tuple beat (valid/ready). Mode load writes one 64-bit
//   hash key; train sets the label's bit in every probed Bloom entry of the
//   RAM; predict scores each class whose bit is set in all probed entries.
//   A predict beat with last_tuple set sends one rsp_* beat per class, in
//   class order, rsp_last on the final one, and clears the scores.
//   csr_wr_data sets the probe count P (0 acts as 1, above 4 as 4).
// Timing:
//   Load and unused-mode beats end at accept. Train and predict beats
//   step through accept, hash, P probe reads of the single-port-read Bloom
//   RAM (one per cycle), and a drain state for the last read. Score beats
//   follow at one per cycle while rsp_ready is high; a stalled receiver holds
//   the output register and the sequencer waits behind it.
// Reset:
//   Scores clear at once; the Bloom RAM is then swept to zero, one entry per
//   cycle, with req_ready low over all 65536 entries. Keys are not cleared.
// ----------------------------------------------------------------------------
module bloom_weightless_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bwc_pkg::PROBES_W-1:0]   csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bwc_pkg::MODE_W-1:0]     req_mode,
   input  logic [bwc_pkg::KEY_IDX_W-1:0]  req_key_index,
   input  logic [bwc_pkg::KEY_W-1:0]      req_key_value,
   input  logic [bwc_pkg::RAM_IDX_W-1:0]  req_ram_index,
   input  logic [bwc_pkg::TUPLE_W-1:0]    req_tuple_bits,
   input  logic [bwc_pkg::LABEL_W-1:0]    req_class_label,
   input  logic                           req_last_tuple,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bwc_pkg::LABEL_W-1:0]    rsp_class_index,
   output logic [bwc_pkg::SCORE_W-1:0]    rsp_score,
   output logic                           rsp_last
);
   import bwc_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [PROBES_W-1:0]    num_probes_ff, num_probes_in;
   logic [PROBE_SEL_W-1:0] probe_ff, probe_in;
   logic [PROBE_SEL_W-1:0] last_probe;
   logic                   rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]      rd_addr_ff, rd_addr_in;
   logic [NUM_CLASSES-1:0] hit_ff, hit_in;
   logic [CLASS_W-1:0]     emit_ff, emit_in;

   logic [MODE_W-1:0]      mode_ff;
   logic [RAM_IDX_W-1:0]   ram_ff;
   logic [TUPLE_W-1:0]     tuple_ff;
   logic [LABEL_W-1:0]     label_ff;
   logic                   last_ff;
   logic [KEY_W-1:0]       hash_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LABEL_W-1:0]     rsp_class_ff, rsp_class_in;
   logic [SCORE_W-1:0]     rsp_score_ff, rsp_score_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   ram_ok;
   logic                   label_ok;
   logic                   out_free;
   logic                   emit_end;
   logic [KEY_W-1:0]       hash;
   logic [FILTER_BITS-1:0] slice;
   logic [NUM_CLASSES-1:0] rd_data;
   logic [NUM_CLASSES-1:0] hit_now;
   logic [SCORE_W-1:0]     sel_score;
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [NUM_CLASSES-1:0] ram_wr_data;
   logic                   ram_rd_en;
   key_wr_type             key_wr;
   score_ctl_type          score_ctl;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign ram_ok    = int'(req_ram_index) < RAM_BANKS;
   assign label_ok  = int'(label_ff) < NUM_CLASSES;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_end  = (emit_ff == CLASS_W'(NUM_CLASSES - 1));

   always_comb begin
      priority if (num_probes_ff == '0) begin
         last_probe = '0;
      end else if (int'(num_probes_ff) > MAX_PROBES) begin
         last_probe = PROBE_SEL_W'(MAX_PROBES - 1);
      end else begin
         last_probe = PROBE_SEL_W'(num_probes_ff - PROBES_W'(1));
      end
   end

   assign slice   = FILTER_BITS'(hash_ff >> {probe_ff, SLICE_SHIFT'(0)});
   assign hit_now = hit_ff & rd_data;

   assign key_wr.en    = accept && req_mode == MODE_LOAD
                         && int'(req_key_index) < TUPLE_BITS;
   assign key_wr.sel   = KEY_SEL_W'(req_key_index);
   assign key_wr.value = req_key_value;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      num_probes_in = csr_wr_en ? csr_wr_data : num_probes_ff;
      probe_in      = probe_ff;
      rd_valid_in   = 1'b0;
      rd_addr_in    = rd_addr_ff;
      hit_in        = hit_ff;
      emit_in       = emit_ff;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = rd_addr_ff;
      ram_wr_data   = rd_data | (NUM_CLASSES'(1) << label_ff);
      score_ctl.inc  = 1'b0;
      score_ctl.hit  = hit_now;
      score_ctl.take = 1'b0;
      score_ctl.sel  = emit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_class_in  = rsp_class_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_last_in   = rsp_last_ff;

      if (rd_valid_ff) begin
         if (mode_ff == MODE_TRAIN) begin
            ram_wr_en = label_ok;
         end else begin
            hit_in = hit_now;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(BLOOM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if ((req_mode == MODE_TRAIN || req_mode == MODE_PREDICT) && ram_ok) begin
                  state_in = ST_HASH;
               end else if (req_mode == MODE_PREDICT && req_last_tuple) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_HASH: begin
            probe_in = '0;
            hit_in   = '1;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            ram_rd_en   = 1'b1;
            rd_valid_in = 1'b1;
            rd_addr_in  = {ram_ff[RAM_SEL_W-1:0], slice};
            probe_in    = probe_ff + PROBE_SEL_W'(1);
            if (probe_ff == last_probe) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            score_ctl.inc = (mode_ff == MODE_PREDICT);
            if (mode_ff == MODE_PREDICT && last_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               score_ctl.take = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_class_in   = LABEL_W'(emit_ff);
               rsp_score_in   = sel_score;
               rsp_last_in    = emit_end;
               emit_in        = emit_ff + CLASS_W'(1);
               if (emit_end) begin
                  emit_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         num_probes_ff <= PROBES_W'(1);
         probe_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         emit_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         num_probes_ff <= num_probes_in;
         probe_ff      <= probe_in;
         rd_valid_ff   <= rd_valid_in;
         emit_ff       <= emit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         ram_ff   <= req_ram_index;
         tuple_ff <= req_tuple_bits;
         label_ff <= req_class_label;
         last_ff  <= req_last_tuple;
      end
      if (state_ff == ST_HASH) begin
         hash_ff <= hash;
      end
      rd_addr_ff   <= rd_addr_in;
      hit_ff       <= hit_in;
      rsp_class_ff <= rsp_class_in;
      rsp_score_ff <= rsp_score_in;
      rsp_last_ff  <= rsp_last_in;
   end

   bwc_hash u_hash (
      .clock  (clock),
      .key_wr (key_wr),
      .tuple  (tuple_ff),
      .hash   (hash)
   );

   bwc_ram #(
      .WIDTH (NUM_CLASSES),
      .DEPTH (BLOOM_DEPTH)
   ) u_bloom (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_in),
      .rd_data (rd_data)
   );

   bwc_score u_score (
      .clock     (clock),
      .reset     (reset),
      .ctl       (score_ctl),
      .sel_score (sel_score)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_class_ff;
   assign rsp_score       = rsp_score_ff;
   assign rsp_last        = rsp_last_ff;

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready && !rsp_valid)
      else $error("beat activity during Bloom clear");

   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> state_ff == ST_CLEAR
                    || (rd_valid_ff && mode_ff == MODE_TRAIN))
      else $error("Bloom write outside clear or train writeback");

   a_last_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_class_index == LABEL_W'(NUM_CLASSES - 1))
      else $error("last score beat not on final class");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> probe_ff <= last_probe)
      else $error("probe counter past probe count");

endmodule
